// ----- rtl/rc_link_frame_parser_top_assert.svh -----
// Assertion macros shared by the frame parser RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RC_LINK_FRAME_PARSER_TOP_ASSERT_SVH
`define RC_LINK_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, reset masked.
`define RCLFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset masked.
`define RCLFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rclfp_pkg.sv -----
// Types, constants and the CRC-8 step function of the RC link frame parser.
// No dependencies; used by the result interface and every module.
package rclfp_pkg;

	localparam int POS_W      = 7;
	localparam int CHAN_IDX_W = 4;
	localparam int LEN_W      = 6;
	localparam int CHAN_BITS  = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [7:0] CRC_POLY      = 8'hD5;
	localparam logic [7:0] SYNC_RESET    = 8'd200;
	localparam logic [7:0] RC_TYPE_RESET = 8'd22;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RC_TYPE = 1'b1;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_ERR  = 2'd1,
		ST_IGN  = 2'd2,
		ST_CHAN = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EMIT = 1'b1
	} fsm_state_t;

	typedef struct packed {
		logic take_byte;
		logic emit_chan;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic rc_good;
		logic chan_last;
	} dp_sts_t;

	// CRC-8, MSB first, one byte
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ----- rtl/rclfp_byte_if.sv -----
// Byte input channel: valid/ready handshake carrying one received byte.
// Depends on nothing.
interface rclfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

// ----- rtl/rclfp_res_if.sv -----
// Result channel: valid/ready handshake carrying one parser result item.
// Depends on rclfp_pkg.
interface rclfp_res_if import rclfp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	status_t               status;
	logic [7:0]            frame_kind;
	logic [LEN_W-1:0]      frame_len;
	logic [CHAN_IDX_W-1:0] chan_index;
	logic [CHAN_BITS-1:0]  chan_value;
	logic                  last;

	modport source (output valid, output status, output frame_kind, output frame_len,
		output chan_index, output chan_value, output last, input ready);
	modport sink (input valid, input status, input frame_kind, input frame_len,
		input chan_index, input chan_value, input last, output ready);
endinterface

// ----- rtl/rclfp_ctrl.sv -----
// Controller FSM: byte intake versus channel burst emission.
// Depends on rclfp_pkg and the assertion macro header.
`include "rc_link_frame_parser_top_assert.svh"

module rclfp_ctrl import rclfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd,
	output logic     in_ready
);

	fsm_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (in_valid && sts.out_free && sts.rc_good) state_nxt = FSM_EMIT;
			end
			FSM_EMIT: begin
				if (sts.out_free && sts.chan_last) state_nxt = FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.take_byte = 1'b0;
		cmd.emit_chan = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				in_ready      = sts.out_free;
				cmd.take_byte = in_valid && sts.out_free;
			end
			FSM_EMIT: begin
				cmd.emit_chan = sts.out_free;
			end
		endcase
	end

	`RCLFP_ASSERT_NOW(a_no_intake_in_burst, clk, arst_n, state_q == FSM_EMIT, !in_ready, "byte taken during channel burst")
	`RCLFP_ASSERT_NEXT(a_good_frame_bursts, clk, arst_n, cmd.take_byte && sts.rc_good, state_q == FSM_EMIT, "good RC frame did not start a burst")

endmodule

// ----- rtl/rclfp_dpath.sv -----
// Datapath: config registers, frame tracking, CRC, payload shift line,
// channel unpacker and the result output register. Depends on rclfp_pkg and the assertion macro header.
`include "rc_link_frame_parser_top_assert.svh"

module rclfp_dpath import rclfp_pkg::*; #(
	parameter int MAX_FRAME_BYTES  = 64,
	parameter int NUM_CHANNELS     = 16,
	parameter int RC_PAYLOAD_BYTES = 22
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [7:0]            byte_in,
	input  ctl_cmd_t              cmd,
	output dp_sts_t               sts,
	input  logic                  out_ready,
	output logic                  out_valid,
	output status_t               status,
	output logic [7:0]            frame_kind,
	output logic [LEN_W-1:0]      frame_len,
	output logic [CHAN_IDX_W-1:0] chan_index,
	output logic [CHAN_BITS-1:0]  chan_value,
	output logic                  last
);

	localparam int PAY_W = RC_PAYLOAD_BYTES * 8;
	localparam logic [7:0]            LEN_MAX  = 8'(MAX_FRAME_BYTES - 2);
	localparam logic [POS_W-1:0]      EXP_RC   = POS_W'(RC_PAYLOAD_BYTES + 4);
	localparam logic [LEN_W-1:0]      LEN_RC   = LEN_W'(RC_PAYLOAD_BYTES + 2);
	localparam logic [CHAN_IDX_W-1:0] CHAN_END = CHAN_IDX_W'(NUM_CHANNELS - 1);

	logic [7:0]            sync_q, rctype_q;
	logic [POS_W-1:0]      pos_q, exp_q;
	logic [7:0]            crc_q, kind_q;
	logic [PAY_W-1:0]      pay_q, unp_q;
	logic [CHAN_IDX_W-1:0] chan_q;

	logic                  out_vld_q;
	status_t               out_status_q;
	logic [7:0]            out_kind_q;
	logic [LEN_W-1:0]      out_len_q;
	logic [CHAN_IDX_W-1:0] out_idx_q;
	logic [CHAN_BITS-1:0]  out_val_q;
	logic                  out_last_q;

	logic       is_hunt, is_len, is_data, is_crc;
	logic       len_bad, crc_ok, kind_ok, len_rc;
	logic [7:0] crc_nxt;
	status_t    byte_status;
	logic [7:0] byte_kind;
	logic [LEN_W-1:0] byte_len;
	logic [POS_W-1:0] frame_len_full;

	// byte classification from the frame position
	always_comb begin
		is_hunt = (pos_q == '0);
		is_len  = (pos_q == POS_W'(1));
		is_data = !is_hunt && !is_len &&
			(({1'b0, pos_q} + 8'd1) < {1'b0, exp_q});
		is_crc  = !is_hunt && !is_len && !is_data;
		len_bad = (byte_in < 8'd2) || (byte_in > LEN_MAX);
		crc_ok  = (byte_in == crc_q);
		kind_ok = (kind_q == rctype_q);
		len_rc  = (exp_q == EXP_RC);
		crc_nxt = crc8_step(crc_q, byte_in);
		frame_len_full = exp_q - POS_W'(2);
	end

	assign sts.out_free  = !out_vld_q || out_ready;
	assign sts.rc_good   = is_crc && crc_ok && kind_ok && len_rc;
	assign sts.chan_last = (chan_q == CHAN_END);

	// single result for an ordinary byte
	always_comb begin
		byte_status = ST_NONE;
		byte_kind   = '0;
		byte_len    = '0;
		if (is_len) begin
			byte_status = len_bad ? ST_ERR : ST_NONE;
		end else if (is_crc) begin
			priority if (!crc_ok) begin
				byte_status = ST_ERR;
			end else if (!kind_ok) begin
				byte_status = ST_IGN;
				byte_kind   = kind_q;
				byte_len    = frame_len_full[LEN_W-1:0];
			end else begin
				// RC type with wrong payload length (good frames never load here)
				byte_status = ST_ERR;
				byte_kind   = kind_q;
				byte_len    = frame_len_full[LEN_W-1:0];
			end
		end
	end

	// config and frame control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q    <= SYNC_RESET;
			rctype_q  <= RC_TYPE_RESET;
			pos_q     <= '0;
			exp_q     <= '0;
			crc_q     <= '0;
			kind_q    <= '0;
			chan_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SYNC:    sync_q   <= cfg_data;
					REG_RC_TYPE: rctype_q <= cfg_data;
				endcase
			end
			if (cmd.take_byte) begin
				if (is_hunt) begin
					if (byte_in == sync_q) pos_q <= POS_W'(1);
				end else if (is_len) begin
					if (len_bad) begin
						pos_q <= '0;
						exp_q <= '0;
					end else begin
						exp_q <= byte_in[POS_W-1:0] + POS_W'(2);
						crc_q <= '0;
						pos_q <= POS_W'(2);
					end
				end else if (is_data) begin
					crc_q <= crc_nxt;
					if (pos_q == POS_W'(2)) kind_q <= byte_in;
					pos_q <= pos_q + POS_W'(1);
				end else begin
					pos_q <= '0;
					exp_q <= '0;
					if (sts.rc_good) chan_q <= '0;
				end
			end
			if (cmd.emit_chan) chan_q <= chan_q + CHAN_IDX_W'(1);
			if ((cmd.take_byte && !sts.rc_good) || cmd.emit_chan) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload shift line, unpacker and output payload
	always_ff @(posedge clk) begin
		if (cmd.take_byte && is_data && pos_q != POS_W'(2)) begin
			pay_q <= {byte_in, pay_q[PAY_W-1:8]};
		end
		if (cmd.take_byte && sts.rc_good) begin
			unp_q <= pay_q;
		end else if (cmd.emit_chan) begin
			unp_q <= unp_q >> CHAN_BITS;
		end
		if (cmd.emit_chan) begin
			out_status_q <= ST_CHAN;
			out_kind_q   <= kind_q;
			out_len_q    <= LEN_RC;
			out_idx_q    <= chan_q;
			out_val_q    <= unp_q[CHAN_BITS-1:0];
			out_last_q   <= sts.chan_last;
		end else if (cmd.take_byte && !sts.rc_good) begin
			out_status_q <= byte_status;
			out_kind_q   <= byte_kind;
			out_len_q    <= byte_len;
			out_idx_q    <= '0;
			out_val_q    <= '0;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid  = out_vld_q;
	assign status     = out_status_q;
	assign frame_kind = out_kind_q;
	assign frame_len  = out_len_q;
	assign chan_index = out_idx_q;
	assign chan_value = out_val_q;
	assign last       = out_last_q;

	`RCLFP_ASSERT_NOW(a_frame_len_sane, clk, arst_n, pos_q >= POS_W'(2), exp_q >= POS_W'(4), "frame body without a valid length")
	`RCLFP_ASSERT_NOW(a_single_is_last, clk, arst_n, out_vld_q && out_status_q != ST_CHAN, out_last_q, "non-channel result not marked last")

endmodule

// ----- rtl/rc_link_frame_parser_top.sv -----
// Top level of the RC link frame parser.
// Depends on rclfp_pkg, rclfp_byte_if, rclfp_res_if, rclfp_ctrl, rclfp_dpath.
//
// Usage:
//  - rx carries one received serial byte per item (valid/ready).
//  - res carries result items: status, frame_kind, frame_len, chan_index,
//    chan_value and last. Every byte gives one item with last set, except the
//    CRC byte of a good RC frame, which gives NUM_CHANNELS channel items,
//    the final one marked last.
//  - cfg_we/cfg_index/cfg_data write sync_value (index 0) and rc_frame_type
//    (index 1); write only while the parser is idle.
// Timing:
//  - An accepted byte shows its result in the output register on the next
//    cycle; a new byte can be taken every cycle while results drain.
//  - A good RC frame loads the unpacker from the payload register with the CRC
//    byte, then gives one channel per cycle while res is ready, out of an 11-bit
//    shift of the unpacker: rx is held not ready until the last channel is emitted.
// Reset (arst_n low): hunting for sync, CRC/type cleared, config back to
//   200 and 22, output register empty.
// Stall: when res is not ready the output register holds its item and rx
//   ready drops; nothing is lost or repeated.
`include "rc_link_frame_parser_top_assert.svh"

module rc_link_frame_parser_top import rclfp_pkg::*; #(
	parameter int MAX_FRAME_BYTES  = 64,
	parameter int NUM_CHANNELS     = 16,
	parameter int RC_PAYLOAD_BYTES = 22
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rclfp_byte_if.sink            rx,
	rclfp_res_if.source           res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;
	logic     in_ready;

	assign rx.ready = in_ready;

	// control: byte intake vs channel burst
	rclfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	// datapath: parsing state, CRC, payload and output register
	rclfp_dpath #(
		.MAX_FRAME_BYTES  (MAX_FRAME_BYTES),
		.NUM_CHANNELS     (NUM_CHANNELS),
		.RC_PAYLOAD_BYTES (RC_PAYLOAD_BYTES)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.byte_in    (rx.byte_in),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (res.ready),
		.out_valid  (res.valid),
		.status     (res.status),
		.frame_kind (res.frame_kind),
		.frame_len  (res.frame_len),
		.chan_index (res.chan_index),
		.chan_value (res.chan_value),
		.last       (res.last)
	);

	// an item is only accepted while the output slot can take its result
	`RCLFP_ASSERT_NEXT(a_accept_loads_output, clk, arst_n, rx.valid && rx.ready && !sts.rc_good, res.valid, "accepted byte produced no result")

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for rc_link_frame_parser_top: byte stream in, result items out.
// Depends on rclfp_pkg, rclfp_byte_if, rclfp_res_if and the parser RTL.

module testbench import rclfp_pkg::*;;

	// must match the parameters handed to the DUT below
	localparam int MAX_FRAME_BYTES  = 64;
	localparam int NUM_CHANNELS     = 16;
	localparam int RC_PAYLOAD_BYTES = 22;
	localparam int RC_FRAME_LEN     = RC_PAYLOAD_BYTES + 2;
	localparam int IDLE_LIMIT       = 1000;
	localparam int PHASE_BYTES      = 18;

	typedef struct packed {
		status_t               status;
		logic [7:0]            kind;
		logic [LEN_W-1:0]      len;
		logic [CHAN_IDX_W-1:0] index;
		logic [CHAN_BITS-1:0]  value;
		logic                  last;
	} parse_result_t;

	// receiver back-pressure patterns
	typedef enum int {
		RDY_ALWAYS,
		RDY_THREE_OF_FOUR,
		RDY_COIN,
		RDY_LONG_STALLS
	} rdy_mode_t;

	// Tracks the parser state byte by byte and holds the results it still owes.
	class frame_scoreboard;
		parse_result_t pending_results[$];
		logic [7:0]    sync_val;
		logic [7:0]    rc_type;
		logic [6:0]    pos;
		logic [6:0]    total;
		logic [7:0]    crc;
		logic [7:0]    kind;
		logic [7:0]    payload[RC_PAYLOAD_BYTES];
		int            errors;
		int            checked;
		int            rc_frames;

		function new();
			sync_val  = SYNC_RESET;
			rc_type   = RC_TYPE_RESET;
			pos       = '0;
			total     = '0;
			crc       = '0;
			kind      = '0;
			errors    = 0;
			checked   = 0;
			rc_frames = 0;
		endfunction

		static function logic [7:0] crc_next(logic [7:0] c_in, logic [7:0] b);
			logic [7:0] c;
			c = c_in ^ b;
			for (int i = 0; i < 8; i++) begin
				if (c[7])
					c = {c[6:0], 1'b0} ^ CRC_POLY;
				else
					c = {c[6:0], 1'b0};
			end
			return c;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			if (idx == REG_SYNC)
				sync_val = val;
			else if (idx == REG_RC_TYPE)
				rc_type = val;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void queue_result(status_t st, logic [7:0] k, logic [6:0] l, int ci,
				logic [CHAN_BITS-1:0] cv, logic lst);
			parse_result_t r;
			r.status = st;
			r.kind   = k;
			r.len    = l[LEN_W-1:0];
			r.index  = ci[CHAN_IDX_W-1:0];
			r.value  = cv;
			r.last   = lst;
			pending_results.push_back(r);
		endfunction

		// one accepted byte -> one result, or a channel burst on a good rc frame
		function void note_byte(logic [7:0] b);
			logic [6:0] len;
			logic [8*RC_PAYLOAD_BYTES+NUM_CHANNELS*CHAN_BITS-1:0] bits;
			if (pos == 0) begin
				if (b == sync_val)
					pos = 7'd1;
				queue_result(ST_NONE, '0, '0, 0, '0, 1'b1);
			end else if (pos == 1) begin
				if (b < 2 || int'(b) > MAX_FRAME_BYTES - 2) begin
					pos   = '0;
					total = '0;
					queue_result(ST_ERR, '0, '0, 0, '0, 1'b1);
				end else begin
					total = 7'(b + 2);
					crc   = '0;
					pos   = 7'd2;
					queue_result(ST_NONE, '0, '0, 0, '0, 1'b1);
				end
			end else if (int'(pos) + 1 < int'(total)) begin
				crc = crc_next(crc, b);
				if (pos == 2)
					kind = b;
				else if (int'(pos) - 3 < RC_PAYLOAD_BYTES)
					payload[int'(pos) - 3] = b;
				pos = pos + 7'd1;
				queue_result(ST_NONE, '0, '0, 0, '0, 1'b1);
			end else begin
				// crc byte closes the frame
				len   = total - 7'd2;
				pos   = '0;
				total = '0;
				if (b != crc) begin
					queue_result(ST_ERR, '0, '0, 0, '0, 1'b1);
				end else if (kind != rc_type) begin
					queue_result(ST_IGN, kind, len, 0, '0, 1'b1);
				end else if (int'(len) != RC_FRAME_LEN) begin
					queue_result(ST_ERR, kind, len, 0, '0, 1'b1);
				end else begin
					// LSB-first bit string; anything past the payload reads zero
					bits = '0;
					for (int i = 0; i < RC_PAYLOAD_BYTES; i++)
						bits[8*i +: 8] = payload[i];
					for (int c = 0; c < NUM_CHANNELS; c++)
						queue_result(ST_CHAN, kind, len, c, bits[CHAN_BITS*c +: CHAN_BITS],
							c == NUM_CHANNELS - 1);
					rc_frames++;
				end
			end
		endfunction

		function void report_field(string field, logic [CHAN_BITS-1:0] want_v,
				logic [CHAN_BITS-1:0] got_v);
			errors++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want_v, got_v);
		endfunction

		function void check_item(parse_result_t got);
			parse_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: status %0d kind %0d len %0d",
					$time, got.status, got.kind, got.len);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.status !== want.status) report_field("status", want.status, got.status);
			if (got.kind !== want.kind) report_field("frame_kind", want.kind, got.kind);
			if (got.len !== want.len) report_field("frame_len", want.len, got.len);
			if (got.index !== want.index) report_field("chan_index", want.index, got.index);
			if (got.value !== want.value) report_field("chan_value", want.value, got.value);
			if (got.last !== want.last) report_field("last", want.last, got.last);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rclfp_byte_if rx_if();
	rclfp_res_if  res_if();

	frame_scoreboard board;
	int              bytes_sent  = 0;
	int              burst_left  = 0;
	bit              gaps_on     = 1'b1;
	int              quiet_cycles = 0;
	rdy_mode_t       rdy_mode    = RDY_ALWAYS;
	int              rdy_timer   = 0;
	int              hold_low    = 0;

	rc_link_frame_parser_top #(
		.MAX_FRAME_BYTES  (MAX_FRAME_BYTES),
		.NUM_CHANNELS     (NUM_CHANNELS),
		.RC_PAYLOAD_BYTES (RC_PAYLOAD_BYTES)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: switches at random between back-pressure patterns, including a
	// pattern that never stalls.
	always @(posedge clk) begin
		if (rdy_timer == 0) begin
			rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
			rdy_timer = $urandom_range(20, 80);
		end else begin
			rdy_timer--;
		end
		case (rdy_mode)
			RDY_ALWAYS: res_if.ready <= 1'b1;
			RDY_THREE_OF_FOUR: res_if.ready <= (rdy_timer % 4 != 0);
			RDY_COIN: res_if.ready <= 1'($urandom_range(0, 1));
			default: begin
				if (hold_low > 0) begin
					hold_low--;
					res_if.ready <= 1'b0;
				end else begin
					res_if.ready <= 1'b1;
					if ($urandom_range(0, 9) == 0)
						hold_low = $urandom_range(1, 12);
				end
			end
		endcase
	end

	// Result monitor: every accepted result item goes straight to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			board.check_item('{status: res_if.status, kind: res_if.frame_kind,
				len: res_if.frame_len, index: res_if.chan_index,
				value: res_if.chan_value, last: res_if.last});
	end

	// Watchdog: a run of cycles with no handshake on either side means a hang.
	always @(posedge clk) begin
		if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog fired after %0d quiet cycles, %0d results owed",
				$time, quiet_cycles, board.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one byte and hold it until taken. The sender runs in bursts; a gap of
	// random length opens each new burst unless gaps are switched off.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 7) : 0;
			if (gap > 0) begin
				rx_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		rx_if.valid   <= 1'b1;
		rx_if.byte_in <= b;
		do @(posedge clk); while (!rx_if.ready);
		board.note_byte(b);
		bytes_sent++;
	endtask

	// Sync, length, then (for a legal length) type, payload and crc.
	// fill < 0 gives random payload, biased toward 0x00, 0xFF and the sync value.
	task automatic send_frame(input logic [7:0] len_b, input logic [7:0] kind,
			input bit bad_crc, input int fill);
		logic [7:0] crc;
		logic [7:0] b;
		send_byte(board.sync_val);
		send_byte(len_b);
		if (len_b < 2 || int'(len_b) > MAX_FRAME_BYTES - 2)
			return;
		send_byte(kind);
		crc = frame_scoreboard::crc_next(8'h00, kind);
		for (int i = 0; i < int'(len_b) - 2; i++) begin
			if (fill >= 0) begin
				b = fill[7:0];
			end else begin
				case ($urandom_range(0, 9))
					0: b = 8'h00;
					1: b = 8'hFF;
					2: b = board.sync_val;
					default: b = 8'($urandom_range(0, 255));
				endcase
			end
			crc = frame_scoreboard::crc_next(crc, b);
			send_byte(b);
		end
		if (bad_crc)
			crc ^= 8'($urandom_range(1, 255));
		send_byte(crc);
	endtask

	// Bring the parser back to hunting, then hold the sender off until every
	// owed result has been taken.
	task automatic settle();
		while (board.pos != 0)
			send_byte(8'($urandom_range(0, 255)));
		rx_if.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write; the caller drops cfg_we after the last one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	// Mostly well-formed frames with random content; the rest are bad lengths,
	// bad crcs, wrong-length rc frames and loose noise bytes.
	task automatic random_phase(input int n_bytes);
		int         stop;
		int         pick;
		logic [7:0] len_b;
		logic [7:0] kind;
		stop = bytes_sent + n_bytes;
		while (bytes_sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_frame(8'(RC_FRAME_LEN), board.rc_type, 1'b0, -1);
			end else if (pick < 55) begin
				kind = 8'($urandom_range(0, 255));
				if (kind == board.rc_type)
					kind = ~kind;
				len_b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(2, MAX_FRAME_BYTES - 2))
					: 8'($urandom_range(2, 8));
				send_frame(len_b, kind, 1'b0, -1);
			end else if (pick < 65) begin
				len_b = 8'($urandom_range(2, 40));
				if (len_b == RC_FRAME_LEN)
					len_b++;
				send_frame(len_b, board.rc_type, 1'b0, -1);
			end else if (pick < 75) begin
				send_frame(8'($urandom_range(2, 30)), 8'($urandom_range(0, 255)), 1'b1, -1);
			end else if (pick < 85) begin
				len_b = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 1))
					: 8'($urandom_range(MAX_FRAME_BYTES - 1, 255));
				send_frame(len_b, 8'h00, 1'b0, -1);
			end else begin
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom_range(0, 255)));
			end
			// now and then let the result side run completely dry
			if ($urandom_range(0, 19) == 0)
				settle();
		end
	endtask

	initial begin
		board         = new();
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		rx_if.valid   = 1'b0;
		rx_if.byte_in = '0;
		res_if.ready  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset register values
		send_byte(8'h00);                                   // noise while hunting
		send_byte(8'hFF);
		send_frame(8'd0, 8'h00, 1'b0, -1);                  // length too short
		send_frame(8'd1, 8'h00, 1'b0, -1);
		send_frame(8'(MAX_FRAME_BYTES - 1), 8'h00, 1'b0, -1); // length too long
		send_frame(8'd255, 8'h00, 1'b0, -1);
		send_frame(8'(RC_FRAME_LEN), board.rc_type, 1'b0, 8'hFF);      // all channels max
		send_frame(8'(RC_FRAME_LEN), board.rc_type, 1'b0, int'(board.sync_val)); // sync as data
		send_frame(8'(RC_FRAME_LEN), board.rc_type, 1'b1, -1);         // crc mismatch
		send_frame(8'd2, 8'h00, 1'b0, -1);                  // shortest frame, other type
		send_frame(8'd3, board.rc_type, 1'b0, 8'h00);       // rc type, wrong length
		send_frame(8'(MAX_FRAME_BYTES - 2), 8'hFF, 1'b0, -1); // longest frame
		random_phase(PHASE_BYTES);

		// extremes of both registers, back-to-back sender
		settle();
		write_reg(REG_SYNC, 8'h00);
		write_reg(REG_RC_TYPE, 8'hFF);
		cfg_we  <= 1'b0;
		gaps_on = 1'b0;
		random_phase(PHASE_BYTES);

		settle();
		write_reg(REG_SYNC, 8'hFF);
		write_reg(REG_RC_TYPE, 8'h00);
		cfg_we  <= 1'b0;
		gaps_on = 1'b1;
		random_phase(PHASE_BYTES);

		settle();
		write_reg(REG_SYNC, 8'($urandom_range(0, 255)));
		write_reg(REG_RC_TYPE, 8'($urandom_range(0, 255)));
		cfg_we <= 1'b0;
		random_phase(PHASE_BYTES);

		settle();
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes under four register settings; checked %0d results,",
			bytes_sent, board.checked);
		$display("including %0d good rc frames, with random sender gaps and stalls.",
			board.rc_frames);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
